>>> sv/spimt_pkg.sv
package spimt_pkg;

  // Width of the analog sample on the input data line.
  localparam int unsigned SAMPLE_BITS = 10;

  // Width of the transmit and receive words.
  localparam int unsigned WORD_BITS = 16;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_CLOCK_POLARITY = 3'd0;
  localparam logic [2:0] REG_CLOCK_PHASE    = 3'd1;
  localparam logic [2:0] REG_LSB_FIRST      = 3'd2;
  localparam logic [2:0] REG_CLOCK_DIVIDER  = 3'd3;
  localparam logic [2:0] REG_THRESHOLD      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]             DIVIDER_RESET   = 8'd2;
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(512);

  // Legal range of the clock divider.
  localparam logic [7:0] DIVIDER_MIN = 8'd2;
  localparam logic [7:0] DIVIDER_MAX = 8'd128;

  // Position inside one bit of the serial clock.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

endpackage

>>> sv/spi_master_threshold_miso.sv
// Channel   Direction  Ports                                          Handshake
// input     in         in_start_req in_tx_word in_wide in_miso_sample in_valid / in_ready
// result    out        out_sck_level out_mosi_level out_busy_res
//                      out_done_res out_rx_word                       out_valid / out_ready
// config    in/out     psel penable pwrite paddr pwdata prdata        pready (always high)
//
// Each input beat is one tick of the serial clock generator and yields exactly one
// result beat. The tick is computed combinationally between the state registers and
// the output register, so a beat is taken every cycle while the result side drains.
// A held result stalls the input side only when out_ready is low.
// Reset (rst_n low, synchronous) returns the shifter to idle and loads the register
// defaults: mode 0, MSB first, divider 2, threshold 512.

module spi_master_threshold_miso (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic [spimt_pkg::WORD_BITS-1:0]   in_tx_word,
  input  logic                              in_wide,
  input  logic [spimt_pkg::SAMPLE_BITS-1:0] in_miso_sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_sck_level,
  output logic                              out_mosi_level,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [spimt_pkg::WORD_BITS-1:0]   out_rx_word,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned WB = spimt_pkg::WORD_BITS;
  localparam int unsigned SB = spimt_pkg::SAMPLE_BITS;

  // Configuration registers
  logic          polarity_r;
  logic          phase_cfg_r;
  logic          lsb_first_r;
  logic [7:0]    divider_r;
  logic [SB-1:0] threshold_r;

  // Transfer state
  logic [WB-1:0]     tx_shift_r, tx_shift_nxt;
  logic [WB-1:0]     rx_shift_r, rx_shift_nxt;
  logic [4:0]        bit_count_r, bit_count_nxt;
  logic [5:0]        half_count_r, half_count_nxt;
  spimt_pkg::phase_t phase_r, phase_nxt;
  logic              active_r, active_nxt;
  logic              is_wide_r, is_wide_nxt;

  // Output register
  logic          out_valid_r;
  logic          sck_r, sck_nxt;
  logic          mosi_r, mosi_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [WB-1:0] rx_word_r, rx_word_nxt;

  logic       in_fire;
  logic       cfg_write;
  logic [2:0] reg_index;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r  <= 1'b0;
      phase_cfg_r <= 1'b0;
      lsb_first_r <= 1'b0;
      divider_r   <= spimt_pkg::DIVIDER_RESET;
      threshold_r <= spimt_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        spimt_pkg::REG_CLOCK_POLARITY: polarity_r  <= pwdata[0];
        spimt_pkg::REG_CLOCK_PHASE:    phase_cfg_r <= pwdata[0];
        spimt_pkg::REG_LSB_FIRST:      lsb_first_r <= pwdata[0];
        spimt_pkg::REG_CLOCK_DIVIDER:  divider_r   <= pwdata[7:0];
        spimt_pkg::REG_THRESHOLD:      threshold_r <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_index)
      spimt_pkg::REG_CLOCK_POLARITY: prdata = {31'd0, polarity_r};
      spimt_pkg::REG_CLOCK_PHASE:    prdata = {31'd0, phase_cfg_r};
      spimt_pkg::REG_LSB_FIRST:      prdata = {31'd0, lsb_first_r};
      spimt_pkg::REG_CLOCK_DIVIDER:  prdata = {24'd0, divider_r};
      spimt_pkg::REG_THRESHOLD:      prdata = {{(32-SB){1'b0}}, threshold_r};
      default:                       prdata = 32'd0;
    endcase
  end

  // Tick logic: start handling, clock and data levels, sampling and bit advance.
  logic          start_now;
  logic          wide_e;
  logic [WB-1:0] tx_e;
  logic [WB-1:0] rx_e;
  logic [4:0]    count_e;
  logic [5:0]    half_e;
  logic          first_e;
  logic [7:0]    div_clamped;
  logic [6:0]    half_len;
  logic          last_tick;
  logic          sample_bit;
  logic          capture;
  logic [4:0]    bits_total;
  logic [4:0]    count_inc;

  always_comb begin
    start_now = !active_r && in_start_req;
    wide_e    = start_now ? in_wide : is_wide_r;
    if (start_now) begin
      tx_e = in_wide ? in_tx_word : {{(WB-8){1'b0}}, in_tx_word[7:0]};
    end else begin
      tx_e = tx_shift_r;
    end
    rx_e    = start_now ? '0 : rx_shift_r;
    count_e = start_now ? 5'd0 : bit_count_r;
    half_e  = start_now ? 6'd0 : half_count_r;
    first_e = start_now || (phase_r == spimt_pkg::PH_FIRST);

    // Half period in ticks, with the divider held to its legal range.
    priority if (divider_r < spimt_pkg::DIVIDER_MIN) begin
      div_clamped = spimt_pkg::DIVIDER_MIN;
    end else if (divider_r > spimt_pkg::DIVIDER_MAX) begin
      div_clamped = spimt_pkg::DIVIDER_MAX;
    end else begin
      div_clamped = divider_r;
    end
    half_len   = div_clamped[7:1];
    last_tick  = ({1'b0, half_e} + 7'd1) >= half_len;
    bits_total = wide_e ? 5'd16 : 5'd8;
    sample_bit = in_miso_sample >= threshold_r;
    capture    = last_tick && (first_e ? !phase_cfg_r : phase_cfg_r);
    count_inc  = count_e + 5'd1;

    // Defaults hold the state.
    tx_shift_nxt   = tx_shift_r;
    rx_shift_nxt   = rx_shift_r;
    bit_count_nxt  = bit_count_r;
    half_count_nxt = half_count_r;
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    is_wide_nxt    = is_wide_r;
    sck_nxt        = polarity_r;
    mosi_nxt       = 1'b0;
    busy_nxt       = active_r || in_start_req;
    done_nxt       = 1'b0;
    rx_word_nxt    = '0;

    if (active_r || in_start_req) begin
      tx_shift_nxt   = tx_e;
      rx_shift_nxt   = rx_e;
      bit_count_nxt  = count_e;
      active_nxt     = 1'b1;
      is_wide_nxt    = wide_e;
      phase_nxt      = first_e ? spimt_pkg::PH_FIRST : spimt_pkg::PH_SECOND;

      if (lsb_first_r) begin
        mosi_nxt = tx_e[0];
      end else begin
        mosi_nxt = wide_e ? tx_e[WB-1] : tx_e[7];
      end
      sck_nxt = polarity_r ^ (first_e ? phase_cfg_r : !phase_cfg_r);

      // Shift the received bit in at the sampling edge.
      if (capture) begin
        if (lsb_first_r) begin
          rx_shift_nxt = rx_e >> 1;
          if (wide_e) begin
            rx_shift_nxt[WB-1] = sample_bit;
          end else begin
            rx_shift_nxt[7] = sample_bit;
          end
        end else begin
          rx_shift_nxt = {rx_e[WB-2:0], sample_bit};
        end
      end

      if (last_tick) begin
        half_count_nxt = 6'd0;
        if (first_e) begin
          phase_nxt = spimt_pkg::PH_SECOND;
        end else begin
          tx_shift_nxt  = lsb_first_r ? (tx_e >> 1) : (tx_e << 1);
          bit_count_nxt = count_inc;
          phase_nxt     = spimt_pkg::PH_FIRST;
          if (count_inc >= bits_total) begin
            done_nxt      = 1'b1;
            rx_word_nxt   = rx_shift_nxt;
            active_nxt    = 1'b0;
            phase_nxt     = spimt_pkg::PH_IDLE;
            bit_count_nxt = 5'd0;
          end
        end
      end else begin
        half_count_nxt = half_e + 6'd1;
      end
    end
  end

  // State registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r   <= '0;
      rx_shift_r   <= '0;
      bit_count_r  <= 5'd0;
      half_count_r <= 6'd0;
      phase_r      <= spimt_pkg::PH_IDLE;
      active_r     <= 1'b0;
      is_wide_r    <= 1'b0;
    end else if (in_fire) begin
      tx_shift_r   <= tx_shift_nxt;
      rx_shift_r   <= rx_shift_nxt;
      bit_count_r  <= bit_count_nxt;
      half_count_r <= half_count_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      is_wide_r    <= is_wide_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sck_r     <= sck_nxt;
      mosi_r    <= mosi_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
      rx_word_r <= rx_word_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sck_level  = sck_r;
  assign out_mosi_level = mosi_r;
  assign out_busy_res   = busy_r;
  assign out_done_res   = done_r;
  assign out_rx_word    = rx_word_r;

endmodule
